// File: sv/verlet_step_with_wall_bounce_unit_assert.svh
// assertion macros for the verlet step unit
`ifndef VERLET_STEP_WITH_WALL_BOUNCE_UNIT_ASSERT_SVH
`define VERLET_STEP_WITH_WALL_BOUNCE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VSWB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define VSWB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/vswb_pkg.sv
// shared types, widths and codes for the verlet step unit
package vswb_pkg;

  localparam int DefPosWidth = 24;
  localparam int DtWidth     = 16;
  localparam int RadWidth    = 16;
  localparam int BoxWidth    = 24;
  localparam int SizeWidth   = 23;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDatWidth = 24;
  localparam int HitWidth    = 2;
  localparam int RoundShift  = 16;

  localparam logic [CfgIdxWidth-1:0] REG_TIME_STEP  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_BOX_LEFT   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_BOX_TOP    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_BOX_WIDTH  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_BOX_HEIGHT = 3'd4;

  localparam logic [HitWidth-1:0] HIT_NONE = 2'd0;
  localparam logic [HitWidth-1:0] HIT_LOW  = 2'd1;
  localparam logic [HitWidth-1:0] HIT_HIGH = 2'd2;
  localparam logic [HitWidth-1:0] HIT_BAD  = 2'd3;

  localparam logic [DtWidth-1:0]   RST_TIME_STEP  = 16'd4096;
  localparam logic [BoxWidth-1:0]  RST_BOX_LEFT   = 24'd0;
  localparam logic [BoxWidth-1:0]  RST_BOX_TOP    = 24'd0;
  localparam logic [SizeWidth-1:0] RST_BOX_WIDTH  = 23'd204800;
  localparam logic [SizeWidth-1:0] RST_BOX_HEIGHT = 23'd153600;

  typedef struct packed {
    logic signed [BoxWidth-1:0] lo;
    logic [SizeWidth-1:0]       size;
  } axis_cfg_t;

  typedef struct packed {
    logic [DtWidth-1:0] dt;
    axis_cfg_t          x;
    axis_cfg_t          y;
  } cfg_t;

endpackage

// File: sv/vswb_cfg.sv
// configuration register file for the verlet step unit
module vswb_cfg
  import vswb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CfgIdxWidth-1:0] wr_index,
  input  logic [CfgDatWidth-1:0] wr_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dt      <= RST_TIME_STEP;
      cfg.x.lo    <= RST_BOX_LEFT;
      cfg.y.lo    <= RST_BOX_TOP;
      cfg.x.size  <= RST_BOX_WIDTH;
      cfg.y.size  <= RST_BOX_HEIGHT;
    end else if (wr_en) begin
      case (wr_index)
        REG_TIME_STEP:  cfg.dt     <= wr_data[DtWidth-1:0];
        REG_BOX_LEFT:   cfg.x.lo   <= wr_data[BoxWidth-1:0];
        REG_BOX_TOP:    cfg.y.lo   <= wr_data[BoxWidth-1:0];
        REG_BOX_WIDTH:  cfg.x.size <= wr_data[SizeWidth-1:0];
        REG_BOX_HEIGHT: cfg.y.size <= wr_data[SizeWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/vswb_axis.sv
// five-stage integrate and wall-bounce datapath for one axis
module vswb_axis
  import vswb_pkg::*;
#(
  parameter int POS_WIDTH = DefPosWidth
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [DtWidth-1:0]          dt,
  input  axis_cfg_t                   acfg,
  input  logic                        low_strict,
  input  logic signed [POS_WIDTH-1:0] pos,
  input  logic signed [POS_WIDTH-1:0] prev,
  input  logic signed [POS_WIDTH-1:0] accel,
  input  logic [RadWidth-1:0]         radius,
  output logic signed [POS_WIDTH-1:0] new_pos,
  output logic signed [POS_WIDTH-1:0] new_prev,
  output logic [HitWidth-1:0]         hit
);

  localparam int W   = POS_WIDTH;
  localparam int P1W = W + DtWidth + 1;       // acc * dt
  localparam int AW  = W + 1;                 // rounded acc * dt
  localparam int P2W = AW + DtWidth + 1;      // a * dt
  localparam int TW  = W + 2;                 // rounded a * dt
  localparam int NW  = W + 3;                 // next position
  localparam int CW  = ((NW > BoxWidth + 2) ? NW : BoxWidth + 2) + 2;
  localparam int SW  = CW + 1;

  localparam logic [P1W:0] HALF1 = (P1W + 1)'(1) << (RoundShift - 1);
  localparam logic [P2W:0] HALF2 = (P2W + 1)'(1) << (RoundShift - 1);

  function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
    logic [SW-W:0] top;
    top = v[SW-1:W-1];
    if ((&top) || !(|top)) begin
      sat = v[W-1:0];
    end else if (v[SW-1]) begin
      sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  logic signed [DtWidth:0] dt_s;
  assign dt_s = $signed({1'b0, dt});

  // stage 1: acc * dt
  logic signed [P1W-1:0]  s1_prod;
  logic signed [W-1:0]    s1_pos, s1_prev;
  logic [RadWidth-1:0]    s1_r;

  // stage 2: round, a * dt
  logic signed [P1W:0]    s2_sum;
  logic signed [AW-1:0]   s2_a;
  logic signed [P2W-1:0]  s2_prod;
  logic signed [W-1:0]    s2_pos, s2_prev;
  logic [RadWidth-1:0]    s2_r;

  // stage 3: round, 2p - q + term
  logic signed [P2W:0]    s3_sum;
  logic signed [TW-1:0]   s3_term;
  logic signed [NW-1:0]   s3_next_c;
  logic signed [NW-1:0]   s3_next;
  logic signed [W-1:0]    s3_pos;
  logic [RadWidth-1:0]    s3_r;

  // stage 4: wall tests
  logic signed [CW-1:0]   nx_e, r_e, lo_e, hi_e, lo_diff, hi_sum;
  logic                   low_hit, high_hit;
  logic signed [CW-1:0]   s4_next, s4_reset;
  logic signed [W-1:0]    s4_pos;
  logic [HitWidth-1:0]    s4_hit;

  // stage 5: resolve and clip
  logic signed [SW-1:0]   pos_e, prev_calc, next_sel;

  assign s2_sum    = $signed({s1_prod[P1W-1], s1_prod}) + $signed(HALF1);
  assign s2_a      = s2_sum[P1W-1:RoundShift];
  assign s3_sum    = $signed({s2_prod[P2W-1], s2_prod}) + $signed(HALF2);
  assign s3_term   = s3_sum[P2W-1:RoundShift];
  assign s3_next_c = ($signed({{3{s2_pos[W-1]}}, s2_pos}) <<< 1)
                   - $signed({{3{s2_prev[W-1]}}, s2_prev})
                   + $signed({s3_term[TW-1], s3_term});

  assign nx_e     = $signed({{(CW-NW){s3_next[NW-1]}}, s3_next});
  assign r_e      = $signed({{(CW-RadWidth){1'b0}}, s3_r});
  assign lo_e     = $signed({{(CW-BoxWidth){acfg.lo[BoxWidth-1]}}, acfg.lo});
  assign hi_e     = lo_e + $signed({{(CW-SizeWidth){1'b0}}, acfg.size});
  assign lo_diff  = nx_e - r_e;
  assign hi_sum   = nx_e + r_e;
  assign low_hit  = low_strict ? (lo_diff < lo_e) : (lo_diff <= lo_e);
  assign high_hit = (hi_sum >= hi_e);

  // mirrored previous: reset - (pos - next)
  assign pos_e     = $signed({{(SW-W){s4_pos[W-1]}}, s4_pos});
  assign prev_calc = $signed({s4_reset[CW-1], s4_reset}) - pos_e
                   + $signed({s4_next[CW-1], s4_next});
  assign next_sel  = (s4_hit == HIT_NONE) ? $signed({s4_next[CW-1], s4_next})
                                          : $signed({s4_reset[CW-1], s4_reset});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod  <= accel * dt_s;
      s1_pos   <= pos;
      s1_prev  <= prev;
      s1_r     <= radius;

      s2_prod  <= s2_a * dt_s;
      s2_pos   <= s1_pos;
      s2_prev  <= s1_prev;
      s2_r     <= s1_r;

      s3_next  <= s3_next_c;
      s3_pos   <= s2_pos;
      s3_r     <= s2_r;

      s4_next  <= nx_e;
      s4_pos   <= s3_pos;
      if (low_hit) begin
        s4_hit   <= HIT_LOW;
        s4_reset <= lo_e + r_e;
      end else if (high_hit) begin
        s4_hit   <= HIT_HIGH;
        s4_reset <= hi_e - r_e;
      end else begin
        s4_hit   <= HIT_NONE;
        s4_reset <= nx_e;
      end

      new_pos  <= sat(next_sel);
      new_prev <= (s4_hit == HIT_NONE) ? s4_pos : sat(prev_calc);
      hit      <= s4_hit;
    end
  end

endmodule

// File: sv/verlet_step_with_wall_bounce_unit.sv
// top level of the verlet step unit: config, valid chain, two axis pipelines
// Verlet step with wall bounce. Each item is one 2-D particle (position,
// previous position, acceleration, radius, all Q.8 with POS_WIDTH-bit
// positions). Both axes are advanced by next = 2*pos - prev + acc*dt*dt,
// where acc*dt and then that times dt are each rounded half up to 8
// fraction bits, and the particle is then bounced off the configured box:
// x left is strict, x right is >=, y top is <=, y bottom is >=; only the
// first wall that matches on an axis is taken. A bounce places the
// particle at the wall offset by its radius and mirrors the previous
// position, so velocity flips sign. Position results saturate to
// POS_WIDTH bits. The unit takes one item every cycle while in_stall is
// low; the stages are the acc*dt multiplier, the rounding plus second dt
// multiplier, the rounding plus 2p - q add, the wall compares, and the
// mirror plus saturation into the output register. The whole pipeline
// holds while a result is stalled at the output, and in_stall is raised
// for exactly those cycles. Configuration (dt, box left/top/width/height)
// is written through the cfg port; the user must write it only while the
// unit is idle, as the block does not enforce it. cfg_ready is always high.
`include "verlet_step_with_wall_bounce_unit_assert.svh"

module verlet_step_with_wall_bounce_unit
  import vswb_pkg::*;
#(
  parameter int POS_WIDTH = DefPosWidth
) (
  input  logic                        clk,
  input  logic                        rst,

  // config write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CfgIdxWidth-1:0]      cfg_index,
  input  logic [CfgDatWidth-1:0]      cfg_data,

  // input item channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [POS_WIDTH-1:0] pos_x,
  input  logic signed [POS_WIDTH-1:0] pos_y,
  input  logic signed [POS_WIDTH-1:0] prev_x,
  input  logic signed [POS_WIDTH-1:0] prev_y,
  input  logic signed [POS_WIDTH-1:0] accel_x,
  input  logic signed [POS_WIDTH-1:0] accel_y,
  input  logic [RadWidth-1:0]         radius,

  // result item channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [POS_WIDTH-1:0] new_pos_x,
  output logic signed [POS_WIDTH-1:0] new_pos_y,
  output logic signed [POS_WIDTH-1:0] new_prev_x,
  output logic signed [POS_WIDTH-1:0] new_prev_y,
  output logic [HitWidth-1:0]         hit_x,
  output logic [HitWidth-1:0]         hit_y
);

  localparam int Depth = 5;

  cfg_t             cfg;
  logic             en;
  // valid bits for stages 1..4; stage 5 is out_valid
  logic [Depth-2:0] vld;

  assign cfg_ready = 1'b1;

  // every stage advances unless a finished result is being held back
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  vswb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[Depth-3:0], in_valid};
      out_valid <= vld[Depth-2];
    end
  end

  // x axis: strict left wall test
  vswb_axis #(.POS_WIDTH(POS_WIDTH)) u_axis_x (
    .clk        (clk),
    .en         (en),
    .dt         (cfg.dt),
    .acfg       (cfg.x),
    .low_strict (1'b1),
    .pos        (pos_x),
    .prev       (prev_x),
    .accel      (accel_x),
    .radius     (radius),
    .new_pos    (new_pos_x),
    .new_prev   (new_prev_x),
    .hit        (hit_x)
  );

  // y axis: top wall test includes equality
  vswb_axis #(.POS_WIDTH(POS_WIDTH)) u_axis_y (
    .clk        (clk),
    .en         (en),
    .dt         (cfg.dt),
    .acfg       (cfg.y),
    .low_strict (1'b0),
    .pos        (pos_y),
    .prev       (prev_y),
    .accel      (accel_y),
    .radius     (radius),
    .new_pos    (new_pos_y),
    .new_prev   (new_prev_y),
    .hit        (hit_y)
  );

  `VSWB_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld[0], "accepted item lost at entry")
  `VSWB_ASSERT_IMP(a_rise_from_pipe, $rose(out_valid), $past(vld[Depth-2]), "result without item")
  `VSWB_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with no backlog")
  `VSWB_ASSERT_IMP(a_hit_codes, out_valid, hit_x != HIT_BAD && hit_y != HIT_BAD, "bad hit code")

endmodule

// File: test/tb.sv
// testbench for the verlet step unit: directed table, random particles, self-checking
module tb
  import vswb_pkg::*;
();

  localparam int     PosW       = DefPosWidth;
  localparam longint PosMax     = (longint'(1) <<< (PosW - 1)) - 1;
  localparam longint PosMin     = -PosMax - 1;
  localparam longint RoundHalf  = longint'(1) <<< (RoundShift - 1);
  localparam int     CycleLimit = 200000;
  localparam int     HoldOff    = 60;
  localparam int     DrainWait  = 20;

  // one particle as it goes into the unit
  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] prev_x;
    logic signed [PosW-1:0] prev_y;
    logic signed [PosW-1:0] accel_x;
    logic signed [PosW-1:0] accel_y;
    logic [RadWidth-1:0]    radius;
  } particle_t;

  // the particle after one step and the bounce
  typedef struct packed {
    logic signed [PosW-1:0] new_pos_x;
    logic signed [PosW-1:0] new_pos_y;
    logic signed [PosW-1:0] new_prev_x;
    logic signed [PosW-1:0] new_prev_y;
    logic [HitWidth-1:0]    hit_x;
    logic [HitWidth-1:0]    hit_y;
  } motion_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct packed {
    particle_t item;
    bit        typed;
    motion_t   want;
  } probe_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CfgIdxWidth-1:0]      cfg_index;
  logic [CfgDatWidth-1:0]      cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [PosW-1:0]      pos_x;
  logic signed [PosW-1:0]      pos_y;
  logic signed [PosW-1:0]      prev_x;
  logic signed [PosW-1:0]      prev_y;
  logic signed [PosW-1:0]      accel_x;
  logic signed [PosW-1:0]      accel_y;
  logic [RadWidth-1:0]         radius;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [PosW-1:0]      new_pos_x;
  logic signed [PosW-1:0]      new_pos_y;
  logic signed [PosW-1:0]      new_prev_x;
  logic signed [PosW-1:0]      new_prev_y;
  logic [HitWidth-1:0]         hit_x;
  logic [HitWidth-1:0]         hit_y;

  // shadow copy of the box and time step
  logic [DtWidth-1:0]          dt_cfg;
  logic signed [BoxWidth-1:0]  left_cfg;
  logic signed [BoxWidth-1:0]  top_cfg;
  logic [SizeWidth-1:0]        width_cfg;
  logic [SizeWidth-1:0]        height_cfg;

  motion_t pending_motion[$];   // predicted results, oldest first
  probe_t  probe_rows[$];       // directed table
  int      failures;
  int      cycles;
  int      in_gap_max;          // longest sender gap per item in this phase
  int      out_gap_max;         // longest receiver stall per result in this phase
  bit      hold_off_req;        // asks the receiver for one long hold-off

  verlet_step_with_wall_bounce_unit #(.POS_WIDTH(PosW)) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .prev_x     (prev_x),
    .prev_y     (prev_y),
    .accel_x    (accel_x),
    .accel_y    (accel_y),
    .radius     (radius),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .new_pos_x  (new_pos_x),
    .new_pos_y  (new_pos_y),
    .new_prev_x (new_prev_x),
    .new_prev_y (new_prev_y),
    .hit_x      (hit_x),
    .hit_y      (hit_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clip to the signed position range
  function automatic logic signed [PosW-1:0] clip_pos(longint v);
    if (v > PosMax) v = PosMax;
    else if (v < PosMin) v = PosMin;
    return PosW'(v);
  endfunction

  // one axis: verlet step, then test against [lo, lo+size) and bounce
  function automatic void advance_axis(input longint p, input longint q, input longint a,
                                       input longint r, input longint lo, input longint size,
                                       input bit strict_low,
                                       output logic signed [PosW-1:0] npos,
                                       output logic signed [PosW-1:0] nprev,
                                       output logic [HitWidth-1:0] hit);
    longint dt, a_dt, a_dt_dt, next, prev, hi, wall;
    bit     low_hit;
    dt      = longint'(dt_cfg);
    // acc*dt and then *dt again, each rounded half up to q.8
    a_dt    = (a * dt + RoundHalf) >>> RoundShift;
    a_dt_dt = (a_dt * dt + RoundHalf) >>> RoundShift;
    next    = 2 * p - q + a_dt_dt;
    prev    = p;
    hi      = lo + size;
    // x left wall is strict, y top wall is not
    low_hit = strict_low ? (next - r < lo) : (next - r <= lo);
    hit     = HIT_NONE;
    if (low_hit) begin
      hit  = HIT_LOW;
      wall = lo + r;
      prev = wall - (prev - next);
      next = wall;
    end else if (next + r >= hi) begin
      hit  = HIT_HIGH;
      wall = hi - r;
      prev = wall - (prev - next);
      next = wall;
    end
    npos  = clip_pos(next);
    nprev = clip_pos(prev);
  endfunction

  // expected result of one particle under the current box and time step
  function automatic motion_t bounce_step(particle_t p);
    motion_t                m;
    logic signed [PosW-1:0] np, nq;
    logic [HitWidth-1:0]    h;
    advance_axis($signed(p.pos_x), $signed(p.prev_x), $signed(p.accel_x),
                 longint'(p.radius), longint'(left_cfg), longint'(width_cfg), 1'b1,
                 np, nq, h);
    m.new_pos_x  = np;
    m.new_prev_x = nq;
    m.hit_x      = h;
    advance_axis($signed(p.pos_y), $signed(p.prev_y), $signed(p.accel_y),
                 longint'(p.radius), longint'(top_cfg), longint'(height_cfg), 1'b0,
                 np, nq, h);
    m.new_pos_y  = np;
    m.new_prev_y = nq;
    m.hit_y      = h;
    return m;
  endfunction

  function automatic particle_t particle(longint px, longint py, longint qx, longint qy,
                                         longint ax, longint ay, longint r);
    particle_t p;
    p.pos_x   = PosW'(px);
    p.pos_y   = PosW'(py);
    p.prev_x  = PosW'(qx);
    p.prev_y  = PosW'(qy);
    p.accel_x = PosW'(ax);
    p.accel_y = PosW'(ay);
    p.radius  = RadWidth'(r);
    return p;
  endfunction

  function automatic motion_t motion(longint npx, longint npy, longint nqx, longint nqy,
                                     logic [HitWidth-1:0] hx, logic [HitWidth-1:0] hy);
    motion_t m;
    m.new_pos_x  = PosW'(npx);
    m.new_pos_y  = PosW'(npy);
    m.new_prev_x = PosW'(nqx);
    m.new_prev_y = PosW'(nqy);
    m.hit_x      = hx;
    m.hit_y      = hy;
    return m;
  endfunction

  task automatic add_row(particle_t p, bit typed, motion_t want);
    probe_t row;
    row.item  = p;
    row.typed = typed;
    row.want  = want;
    probe_rows.push_back(row);
  endtask

  // a coordinate around the box on one axis, with some margin past both walls
  function automatic logic signed [PosW-1:0] near_wall(longint lo, longint size);
    longint margin, off;
    margin = size / 8 + 1024;
    off    = longint'($urandom_range(0, 32'(size + 2 * margin)));
    return clip_pos(lo - margin + off);
  endfunction

  // mostly particles moving near the box, some pure noise
  function automatic particle_t random_particle();
    particle_t p;
    longint    vx, vy;
    int        mode;
    mode      = $urandom_range(0, 9);
    p.pos_x   = PosW'($urandom);
    p.pos_y   = PosW'($urandom);
    p.prev_x  = PosW'($urandom);
    p.prev_y  = PosW'($urandom);
    p.accel_x = PosW'($urandom);
    p.accel_y = PosW'($urandom);
    p.radius  = RadWidth'($urandom);
    if (mode >= 2) begin
      p.pos_x   = near_wall(longint'(left_cfg), longint'(width_cfg));
      p.pos_y   = near_wall(longint'(top_cfg), longint'(height_cfg));
      vx        = longint'($urandom_range(0, 4096)) - 2048;
      vy        = longint'($urandom_range(0, 4096)) - 2048;
      p.prev_x  = clip_pos($signed(p.pos_x) - vx);
      p.prev_y  = clip_pos($signed(p.pos_y) - vy);
      p.accel_x = PosW'(longint'($urandom_range(0, 65536)) - 32768);
      p.accel_y = PosW'(longint'($urandom_range(0, 65536)) - 32768);
      if (mode < 8) p.radius = RadWidth'($urandom_range(0, 4095));
    end
    return p;
  endfunction

  // register write; cfg_valid stays high so writes can go back to back
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDatWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TIME_STEP:  dt_cfg     = data[DtWidth-1:0];
      REG_BOX_LEFT:   left_cfg   = data[BoxWidth-1:0];
      REG_BOX_TOP:    top_cfg    = data[BoxWidth-1:0];
      REG_BOX_WIDTH:  width_cfg  = data[SizeWidth-1:0];
      REG_BOX_HEIGHT: height_cfg = data[SizeWidth-1:0];
      default: ;
    endcase
  endtask

  // full box setup; a stray write to an unused index goes last so aliasing shows
  task automatic load_box(input logic [CfgDatWidth-1:0] dt, input logic [CfgDatWidth-1:0] left,
                          input logic [CfgDatWidth-1:0] top, input logic [CfgDatWidth-1:0] width,
                          input logic [CfgDatWidth-1:0] height, input bit stray);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_BOX_LEFT, left);
    write_reg(REG_BOX_TOP, top);
    write_reg(REG_BOX_WIDTH, width);
    write_reg(REG_BOX_HEIGHT, height);
    if (stray)
      write_reg(CfgIdxWidth'($urandom_range(REG_BOX_HEIGHT + 1, (1 << CfgIdxWidth) - 1)),
                CfgDatWidth'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_motion.size() != 0);
  endtask

  // offer one particle; the prediction is taken at the accepting edge
  task automatic send_particle(particle_t p, bit typed, motion_t want, bit pause_first);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (pause_first) wait_drained();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= p.pos_x;
    pos_y    <= p.pos_y;
    prev_x   <= p.prev_x;
    prev_y   <= p.prev_y;
    accel_x  <= p.accel_x;
    accel_y  <= p.accel_y;
    radius   <= p.radius;
    do @(posedge clk); while (in_stall);
    pending_motion.push_back(typed ? want : bounce_step(p));
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // receiver: check each result, then stall for a drawn number of cycles
  initial begin
    int      stall_left;
    int      hold_left;
    motion_t got;
    motion_t want;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.new_pos_x  = new_pos_x;
        got.new_pos_y  = new_pos_y;
        got.new_prev_x = new_prev_x;
        got.new_prev_y = new_prev_y;
        got.hit_x      = hit_x;
        got.hit_y      = hit_y;
        if (pending_motion.size() == 0) begin
          $error("result item with no particle outstanding");
          failures++;
        end else begin
          want = pending_motion.pop_front();
          check_field("new_pos_x", $signed(want.new_pos_x), $signed(got.new_pos_x));
          check_field("new_pos_y", $signed(want.new_pos_y), $signed(got.new_pos_y));
          check_field("new_prev_x", $signed(want.new_prev_x), $signed(got.new_prev_x));
          check_field("new_prev_y", $signed(want.new_prev_y), $signed(got.new_prev_y));
          check_field("hit_x", want.hit_x, got.hit_x);
          check_field("hit_y", want.hit_y, got.hit_y);
        end
        stall_left = $urandom_range(0, out_gap_max);
      end
      // a long hold-off lets the pipeline fill and push back on the input
      if (hold_off_req) begin
        hold_left    = HoldOff;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int n_items;
    // everything known from time zero
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    pos_x        = '0;
    pos_y        = '0;
    prev_x       = '0;
    prev_y       = '0;
    accel_x      = '0;
    accel_y      = '0;
    radius       = '0;
    out_stall    = 1'b0;
    failures     = 0;
    hold_off_req = 1'b0;
    in_gap_max   = 12;
    out_gap_max  = 12;
    dt_cfg       = RST_TIME_STEP;
    left_cfg     = RST_BOX_LEFT;
    top_cfg      = RST_BOX_TOP;
    width_cfg    = RST_BOX_WIDTH;
    height_cfg   = RST_BOX_HEIGHT;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table, run on the reset box [0,800) x [0,600) with dt 1/16
    // particle at rest inside
    add_row(particle(25600, 25600, 25600, 25600, 0, 0, 0), 1'b1,
            motion(25600, 25600, 25600, 25600, HIT_NONE, HIT_NONE));
    // all zero: touches the top wall, which is inclusive
    add_row(particle(0, 0, 0, 0, 0, 0, 0), 1'b1,
            motion(0, 0, 0, 0, HIT_NONE, HIT_LOW));
    // full-range velocity to the right, mirrored previous saturates
    add_row(particle(PosMax, 25600, PosMin, 25600, 0, 0, 0), 1'b1,
            motion(204800, 25600, PosMax, 25600, HIT_HIGH, HIT_NONE));
    // full-range velocity to the left
    add_row(particle(PosMin, 25600, PosMax, 25600, 0, 0, 0), 1'b1,
            motion(0, 25600, PosMin, 25600, HIT_LOW, HIT_NONE));
    // full-range velocity down and up
    add_row(particle(25600, PosMax, 25600, PosMin, 0, 0, 0), 1'b1,
            motion(25600, 153600, 25600, PosMax, HIT_NONE, HIT_HIGH));
    add_row(particle(25600, PosMin, 25600, PosMax, 0, 0, 0), 1'b1,
            motion(25600, 0, 25600, PosMin, HIT_NONE, HIT_LOW));
    // acceleration extremes
    add_row(particle(102400, 76800, 102400, 76800, PosMax, PosMin, 0), 1'b0, '0);
    add_row(particle(102400, 76800, 102400, 76800, PosMin, PosMax, 0), 1'b0, '0);
    // largest radius: the particle overlaps the left and top walls
    add_row(particle(25600, 25600, 25600, 25600, 0, 0, 16'hFFFF), 1'b0, '0);
    // exactly on the left edge (no hit) and the top edge (hit)
    add_row(particle(1000, 1000, 1000, 1000, 0, 0, 1000), 1'b0, '0);
    // one step past the left edge
    add_row(particle(999, 2000, 999, 2000, 0, 0, 1000), 1'b0, '0);
    // exactly on the right and bottom edges, both inclusive
    add_row(particle(203800, 152600, 203800, 152600, 0, 0, 1000), 1'b0, '0);
    // one step short of the right and bottom edges
    add_row(particle(203799, 152599, 203799, 152599, 0, 0, 1000), 1'b0, '0);
    // every field at its top, then at its bottom
    add_row(particle(PosMax, PosMax, PosMax, PosMax, PosMax, PosMax, 16'hFFFF), 1'b0, '0);
    add_row(particle(PosMin, PosMin, PosMin, PosMin, PosMin, PosMin, 0), 1'b0, '0);
    // moving particles inside, small acceleration
    add_row(particle(50000, 40000, 49000, 40500, 300, -300, 256), 1'b0, '0);
    // alternating bit patterns
    add_row(particle(24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555,
                     24'sh555555, 24'shAAAAAA, 16'hAAAA), 1'b0, '0);
    add_row(particle(24'shAAAAAA, 24'sh555555, 24'sh555555, 24'shAAAAAA,
                     24'shAAAAAA, 24'sh555555, 16'h5555), 1'b0, '0);
    foreach (probe_rows[i])
      send_particle(probe_rows[i].item, probe_rows[i].typed, probe_rows[i].want, 1'b0);
    wait_drained();

    // random phases, each with its own box and idle pattern
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          // widest box, largest dt; upper bits of the dt write must be dropped
          load_box(24'hFFFFFF, CfgDatWidth'(PosMin), CfgDatWidth'(PosMin),
                   24'h7FFFFF, 24'h7FFFFF, 1'b0);
          in_gap_max  = 0;
          out_gap_max = 0;
          n_items     = 80;
        end
        1: begin
          // empty box at the far corner, dt zero: every axis bounces
          load_box('0, CfgDatWidth'(PosMax), CfgDatWidth'(PosMax), '0, '0, 1'b1);
          in_gap_max  = 12;
          out_gap_max = 12;
          n_items     = 60;
        end
        default: begin
          if ($urandom_range(0, 3) == 0)
            load_box(CfgDatWidth'($urandom), CfgDatWidth'($urandom), CfgDatWidth'($urandom),
                     CfgDatWidth'($urandom), CfgDatWidth'($urandom), 1'b1);
          else
            load_box(CfgDatWidth'($urandom),
                     CfgDatWidth'(longint'($urandom_range(0, 131072)) - 65536),
                     CfgDatWidth'(longint'($urandom_range(0, 131072)) - 65536),
                     {1'($urandom), 23'($urandom_range(0, 1 << 19))},
                     {1'($urandom), 23'($urandom_range(0, 1 << 19))}, 1'b1);
          in_gap_max  = (phase == 2 || phase == 4) ? 0 : 12;
          out_gap_max = (phase == 3) ? 0 : ((phase == 2) ? 3 : 12);
          n_items     = 90;
        end
      endcase
      for (int k = 0; k < n_items; k++) begin
        // pressure: long output hold-off while input keeps coming
        if (phase == 2 && k == 5) hold_off_req = 1'b1;
        // pressure: sender pauses until nothing is outstanding
        send_particle(random_particle(), 1'b0, '0, phase == 2 && k == 45);
      end
      wait_drained();
    end

    // let any stray result surface before the verdict
    repeat (DrainWait) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
